@@ sv/match_inlier_counter_macros.svh @@
// ---------------------------------------------------------------------------
// match_inlier_counter_macros : assertion macros
// Shorthand for the concurrent checks of the inlier counter, clocked on clk
// and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MATCH_INLIER_COUNTER_MACROS_SVH
`define MATCH_INLIER_COUNTER_MACROS_SVH

// Same-cycle implication
`define MIC_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("match_inlier_counter: same-cycle check failed");

// Next-cycle implication
`define MIC_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("match_inlier_counter: next-cycle check failed");

`endif

@@ sv/mic_pkg.sv @@
// ---------------------------------------------------------------------------
// mic_pkg : shared types and constants of the match inlier counter
// Widths of the datapath, register indexes, reset values, sequencer states
// and the control group of the shared multiply-accumulate unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mic_pkg;

  // Datapath widths
  localparam int ACC_W   = 40;   // accumulator, holds every sum of two products
  localparam int MUL_A_W = 20;   // signed A operand: coordinate, extent*8 or px/py
  localparam int MUL_B_W = 17;   // signed B operand: scale, cosine or sine
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int PX_W    = 20;   // centred canvas coordinate
  localparam int SCORE_W = 16;
  localparam int CFG_AW  = 3;

  localparam int KEYPOINTS_DEF = 1024;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  // Fraction bits removed after placing and after rotating
  localparam logic [4:0] FRAC_PLACE = 5'd16;
  localparam logic [4:0] FRAC_ROT   = 5'd14;

  // |matched - 16*rotated| below this gives an integer offset of at most one,
  // which is a squared distance below four
  localparam logic signed [ACC_W-1:0] NEAR_LIM = 40'sd32;

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_COS    = 3'd1,
    CFG_SIN    = 3'd2,
    CFG_CENTER = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_reg_t;

  // Reset values
  localparam logic [15:0]        SCALE_RST  = 16'd4096;
  localparam logic signed [15:0] COS_RST    = 16'sd16384;
  localparam logic signed [15:0] SIN_RST    = 16'sd0;
  localparam logic [12:0]        CENTER_RST = 13'd0;
  localparam logic [12:0]        WIDTH_RST  = 13'd640;
  localparam logic [12:0]        HEIGHT_RST = 13'd480;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_TAKE,
    ST_FIN,
    ST_WRITE
  } mic_state_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic load;     // acc <= load value
    logic mul_en;   // product register <= a * b
    logic acc_en;   // acc <= acc +/- product
    logic sub;      // subtract instead of add
  } mac_ctrl_t;

  // Arithmetic shift right that rounds toward zero
  function automatic logic signed [ACC_W-1:0] trunc_shift(
    input logic signed [ACC_W-1:0] v,
    input logic [4:0]              k
  );
    logic signed [ACC_W-1:0] bias;
    logic signed [ACC_W-1:0] sum;
    bias = v[ACC_W-1] ? $signed((ACC_W'(1) << k) - ACC_W'(1)) : '0;
    sum  = v + bias;
    return sum >>> k;
  endfunction

endpackage

@@ sv/match_inlier_counter.sv @@
// Matches are taken one at a time: a new match is accepted only after the last
// result is presented; eight passes through the one shared multiplier (multiply,
// then accumulate) and four truncation steps lie between.
// Reset: synchronous, rst_n low; configuration and control registers return to
// reset values and a clearing pass writes zero to every score entry, in_tready low.
// ---------------------------------------------------------------------------
// match_inlier_counter : ground-truth inlier counter for feature matches
// Projects each reference keypoint through scale, canvas offset and rotation
// on a shared multiply-accumulate unit, tests the distance to the matched
// point and keeps a saturating score per reference keypoint.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module match_inlier_counter
  import mic_pkg::*;
#(
  parameter int KEYPOINTS = KEYPOINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input matches
  input  logic              in_tvalid,
  output logic              in_tready,
  // [9:0] ref_index, [25:10] ref_x, [41:26] ref_y, [58:42] matched_x,
  // [75:59] matched_y, [79:76] zero
  input  logic [79:0]       in_tdata,
  // Results
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] is_correct, [16:1] score_now, [23:17] zero
  output logic [23:0]       out_tdata,
  // Configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [15:0]       cfg_data
);

  `include "match_inlier_counter_macros.svh"

  localparam int AW = (KEYPOINTS > 1) ? $clog2(KEYPOINTS) : 1;

  // Step numbers at which a pair of products is complete
  localparam logic [2:0] STEP_PX = 3'd1;
  localparam logic [2:0] STEP_PY = 3'd3;
  localparam logic [2:0] STEP_RX = 3'd5;
  localparam logic [2:0] STEP_RY = 3'd7;

  // Configuration registers
  logic [15:0]        scale_r;
  logic signed [15:0] cos_r;
  logic signed [15:0] sin_r;
  logic [12:0]        center_r;
  logic [12:0]        width_r;
  logic [12:0]        height_r;

  // Sequencer
  mic_state_t         state_r, state_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;

  // Latched match
  logic [9:0]         idx_r;
  logic [15:0]        ref_x_r, ref_y_r;
  logic [16:0]        m_x_r, m_y_r;

  // Intermediate results
  logic signed [ACC_W-1:0] res_r, res_nxt;
  logic signed [PX_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic                    hit_x_r, hit_x_nxt, hit_r, hit_nxt;

  // Output register
  logic               out_tvalid_r, out_tvalid_nxt;
  logic               out_correct_r, out_correct_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;

  // Shared unit
  mac_ctrl_t                mac_ctrl;
  logic signed [ACC_W-1:0]  mac_load;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic                     op_sub;
  logic signed [ACC_W-1:0]  acc;

  // Score store
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, idx_addr;
  logic [SCORE_W-1:0] ram_wdata, ram_rdata;

  logic                    in_xfer, idx_ok;
  logic [SCORE_W-1:0]      score_new;
  logic signed [ACC_W-1:0] center_ext, near_diff;
  logic signed [ACC_W-1:0] m_sel;
  logic                    near;
  logic signed [ACC_W-1:0] res_minus_c;

  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_score_r, out_correct_r};
  assign idx_addr   = AW'(idx_r);
  assign idx_ok     = 32'(idx_r) < KEYPOINTS;
  assign center_ext = $signed(ACC_W'(center_r));

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
      center_r <= CENTER_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        CFG_SCALE:  scale_r  <= cfg_data;
        CFG_COS:    cos_r    <= $signed(cfg_data);
        CFG_SIN:    sin_r    <= $signed(cfg_data);
        CFG_CENTER: center_r <= cfg_data[12:0];
        CFG_WIDTH:  width_r  <= cfg_data[12:0];
        CFG_HEIGHT: height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted match
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r   <= in_tdata[9:0];
      ref_x_r <= in_tdata[25:10];
      ref_y_r <= in_tdata[41:26];
      m_x_r   <= in_tdata[58:42];
      m_y_r   <= in_tdata[75:59];
    end
  end

  // Operand select for each product step
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (step_r)
      3'd0: begin
        op_a = $signed(MUL_A_W'(ref_x_r));
        op_b = $signed(MUL_B_W'(scale_r));
      end
      3'd1: begin
        op_a   = $signed(MUL_A_W'({width_r, 3'b000}));
        op_b   = $signed(MUL_B_W'(scale_r));
        op_sub = 1'b1;
      end
      3'd2: begin
        op_a = $signed(MUL_A_W'(ref_y_r));
        op_b = $signed(MUL_B_W'(scale_r));
      end
      3'd3: begin
        op_a   = $signed(MUL_A_W'({height_r, 3'b000}));
        op_b   = $signed(MUL_B_W'(scale_r));
        op_sub = 1'b1;
      end
      3'd4: begin
        op_a = px_r;
        op_b = MUL_B_W'(cos_r);
      end
      3'd5: begin
        op_a   = py_r;
        op_b   = MUL_B_W'(sin_r);
        op_sub = 1'b1;
      end
      3'd6: begin
        op_a = px_r;
        op_b = MUL_B_W'(sin_r);
      end
      default: begin
        op_a = py_r;
        op_b = MUL_B_W'(cos_r);
      end
    endcase
  end

  // Distance test of the rotated point against the matched one
  assign m_sel       = (step_r == STEP_RX) ? $signed(ACC_W'(m_x_r)) : $signed(ACC_W'(m_y_r));
  assign near_diff   = m_sel - (res_r <<< 4);
  assign near        = (near_diff > -NEAR_LIM) && (near_diff < NEAR_LIM);
  assign res_minus_c = res_r - center_ext;

  // Saturating score update
  assign score_new = (hit_r && (ram_rdata != SCORE_MAX)) ? ram_rdata + SCORE_W'(1) : ram_rdata;

  mic_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .load_val (mac_load),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc      (acc)
  );

  mic_score_ram #(
    .DEPTH (KEYPOINTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(in_tdata[9:0])),
    .rdata (ram_rdata)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= '0;
      clr_addr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    res_r         <= res_nxt;
    px_r          <= px_nxt;
    py_r          <= py_nxt;
    hit_x_r       <= hit_x_nxt;
    hit_r         <= hit_nxt;
    out_correct_r <= out_correct_nxt;
    out_score_r   <= out_score_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    clr_addr_nxt    = clr_addr_r;
    res_nxt         = res_r;
    px_nxt          = px_r;
    py_nxt          = py_r;
    hit_x_nxt       = hit_x_r;
    hit_nxt         = hit_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_correct_nxt = out_correct_r;
    out_score_nxt   = out_score_r;
    in_tready       = 1'b0;
    mac_ctrl.load   = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_en = 1'b0;
    mac_ctrl.sub    = op_sub;
    mac_load        = center_ext <<< FRAC_PLACE;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = idx_addr;
    ram_wdata       = score_new;

    unique case (state_r)
      // Sweep zeros through the score store
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == AW'(KEYPOINTS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      // Take a match, start the score read and preload the centre term
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ram_re        = 1'b1;
          mac_ctrl.load = 1'b1;
          step_nxt      = '0;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (step_r[0]) begin
          state_nxt = ST_TAKE;
        end else begin
          step_nxt  = step_r + 3'd1;
          state_nxt = ST_MUL;
        end
      end
      // Drop the fraction, rounding toward zero
      ST_TAKE: begin
        res_nxt   = trunc_shift(acc, step_r[2] ? FRAC_ROT : FRAC_PLACE);
        state_nxt = ST_FIN;
      end
      // Finish the coordinate or hit test; preload for the next pair unless it was the last
      ST_FIN: begin
        step_nxt  = step_r + 3'd1;
        state_nxt = ST_MUL;
        case (step_r)
          STEP_PX: begin
            px_nxt        = res_minus_c[PX_W-1:0];
            mac_ctrl.load = 1'b1;
          end
          STEP_PY: begin
            py_nxt        = res_minus_c[PX_W-1:0];
            mac_ctrl.load = 1'b1;
            mac_load      = center_ext <<< FRAC_ROT;
          end
          STEP_RX: begin
            hit_x_nxt     = near;
            mac_ctrl.load = 1'b1;
            mac_load      = center_ext <<< FRAC_ROT;
          end
          STEP_RY: begin
            hit_nxt   = hit_x_r && near;
            state_nxt = ST_WRITE;
          end
          default: ;
        endcase
      end
      // Update the score and present the result once the output is free
      ST_WRITE: begin
        if (!out_tvalid_r || out_tready) begin
          ram_we          = idx_ok;
          out_tvalid_nxt  = 1'b1;
          out_correct_nxt = hit_r;
          out_score_nxt   = idx_ok ? score_new : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Checks
  `MIC_ASSERT_IMP(a_no_take_in_clear, state_r == ST_CLEAR, !in_tready)
  `MIC_ASSERT_NXT(a_one_at_a_time, in_xfer, !in_tready)
  `MIC_ASSERT_IMP(a_result_from_write, $rose(out_tvalid), $past(state_r) == ST_WRITE)

endmodule

@@ sv/mic_mac.sv @@
// ---------------------------------------------------------------------------
// mic_mac : shared multiply-accumulate unit
// One signed multiplier with a product register, followed by an add or
// subtract into a wide accumulator that can be preloaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_mac
  import mic_pkg::*;
(
  input  logic                       clk,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [ACC_W-1:0]    load_val,
  input  logic signed [MUL_A_W-1:0]  op_a,
  input  logic signed [MUL_B_W-1:0]  op_b,
  output logic signed [ACC_W-1:0]    acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = ACC_W'(prod_r);
  assign acc      = acc_r;

  // Multiply into the product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  // Preload or accumulate
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_r <= load_val;
    end else if (ctrl.acc_en) begin
      acc_r <= ctrl.sub ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

endmodule

@@ sv/mic_score_ram.sv @@
// ---------------------------------------------------------------------------
// mic_score_ram : score store
// Single write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_score_ram
  import mic_pkg::*;
#(
  parameter int DEPTH = KEYPOINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [SCORE_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [SCORE_W-1:0] rdata
);

  logic [SCORE_W-1:0] mem [DEPTH];
  logic [SCORE_W-1:0] rdata_r;

  assign rdata = rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top : self-checking bench for the match inlier counter
// Streams feature matches into the block under several register settings and
// compares every verdict and score against a projection and score store kept
// alongside. Hand-worked rows come first, then matches drawn near the
// projected point so that hits, near misses and rising scores all occur.
// ---------------------------------------------------------------------------

module tb_top;
  import mic_pkg::*;

  localparam int KEYPOINTS       = KEYPOINTS_DEF;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int SHOWN_MAX       = 10;
  localparam int SETTLE_CYCLES   = 40;
  localparam longint NEAR_SQ     = 4;

  // Indexes that decode to no register
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [9:0]  ref_index;
    logic [15:0] ref_x;
    logic [15:0] ref_y;
    logic [16:0] matched_x;
    logic [16:0] matched_y;
  } match_t;

  typedef struct packed {
    logic               is_correct;
    logic [SCORE_W-1:0] score_now;
  } verdict_t;

  // One row of the hand-worked table; typed marks a verdict worked out by hand
  typedef struct packed {
    match_t   m;
    bit       typed;
    verdict_t v;
  } probe_t;

  // Raw write data for the six registers
  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] cosv;
    logic [15:0] sinv;
    logic [15:0] centre;
    logic [15:0] width;
    logic [15:0] height;
  } reg_set_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  bit calm = 1'b0;
  bit gappy = 1'b1;
  int fault_count = 0;

  // Register copies and score store of the predictor
  logic [15:0]        scale_q = SCALE_RST;
  logic signed [15:0] cos_q = COS_RST;
  logic signed [15:0] sin_q = SIN_RST;
  logic [12:0]        centre_q = CENTER_RST;
  logic [12:0]        width_q = WIDTH_RST;
  logic [12:0]        height_q = HEIGHT_RST;
  logic [SCORE_W-1:0] hit_count [KEYPOINTS];

  verdict_t verdicts_due [$];

  // Worked under the reset registers: px = x/16 - 320, py = y/16 - 240, no rotation
  probe_t probes [16] = '{
    '{'{10'd0, 16'd5120, 16'd3840, 17'd0, 17'd0}, 1'b1, '{1'b1, 16'd1}},
    '{'{10'd0, 16'd5120, 16'd3840, 17'd0, 17'd0}, 1'b1, '{1'b1, 16'd2}},
    '{'{10'd0, 16'd5120, 16'd3840, 17'd32, 17'd0}, 1'b1, '{1'b0, 16'd2}},
    '{'{10'd0, 16'd5120, 16'd3840, 17'd31, 17'd31}, 1'b1, '{1'b1, 16'd3}},
    '{'{10'd0, 16'd5120, 16'd3840, 17'd0, 17'd32}, 1'b1, '{1'b0, 16'd3}},
    '{'{10'd1, 16'd0, 16'd0, 17'd0, 17'd0}, 1'b1, '{1'b0, 16'd0}},
    '{'{10'd1023, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF}, 1'b1, '{1'b0, 16'd0}},
    '{'{10'd1023, 16'd6720, 16'd4640, 17'd1600, 17'd800}, 1'b1, '{1'b1, 16'd1}},
    // fraction just below the next pixel, then a small negative sum cut to zero
    '{'{10'd2, 16'd5135, 16'd3840, 17'd0, 17'd0}, 1'b1, '{1'b1, 16'd1}},
    '{'{10'd2, 16'd5119, 16'd3840, 17'd0, 17'd0}, 1'b1, '{1'b1, 16'd2}},
    // negative offsets round toward zero
    '{'{10'd3, 16'd5152, 16'd3840, 17'd1, 17'd0}, 1'b1, '{1'b1, 16'd1}},
    '{'{10'd3, 16'd5152, 16'd3840, 17'd0, 17'd0}, 1'b1, '{1'b0, 16'd1}},
    '{'{10'd3, 16'd5120, 16'd3824, 17'd0, 17'd0}, 1'b1, '{1'b1, 16'd2}},
    '{'{10'h155, 16'hAAAA, 16'h5555, 17'h15555, 17'h0AAAA}, 1'b0, '0},
    '{'{10'h2AA, 16'h5555, 16'hAAAA, 17'h0AAAA, 17'h15555}, 1'b0, '0},
    '{'{10'd0, 16'd0, 16'hFFFF, 17'd0, 17'h1FFFF}, 1'b0, '0}
  };

  reg_set_t fixed_sets [5] = '{
    '{16'd4096, 16'd16384, 16'd0, 16'd2048, 16'd640, 16'd480},
    '{16'd8192, 16'd0, 16'd16384, 16'd4096, 16'd1024, 16'd768},
    '{16'd65535, 16'hC000, 16'hC000, 16'd8191, 16'd4096, 16'd4096},
    '{16'd0, 16'd11585, 16'd11585, 16'd0, 16'd1, 16'd1},
    // bits beyond the stated ranges, upper bits of the 13-bit registers set
    '{16'd2048, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hE000, 16'h3FFF}
  };

  match_inlier_counter #(
    .KEYPOINTS(KEYPOINTS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Scale, place on the canvas and rotate one reference point, whole pixels
  function automatic void project_point(input logic [15:0] x, input logic [15:0] y,
                                        output longint rx, output longint ry);
    longint s, c, cs, sn, xs, ys, wd, ht, px, py;
    s  = scale_q;
    c  = centre_q;
    cs = cos_q;
    sn = sin_q;
    xs = x;
    ys = y;
    wd = width_q;
    ht = height_q;
    px = (xs * s + c * 65536 - wd * s * 8) / 65536 - c;
    py = (ys * s + c * 65536 - ht * s * 8) / 65536 - c;
    rx = (c * 16384 + px * cs - py * sn) / 16384;
    ry = (c * 16384 + px * sn + py * cs) / 16384;
  endfunction

  // Verdict for one match; bump its score on a hit, holding at the top.
  // Reaching the top needs 65535 hits on one entry, beyond a run this length.
  function automatic verdict_t judge_match(input match_t m);
    verdict_t           v;
    longint             rx, ry, mx, my, dx, dy;
    logic [SCORE_W-1:0] sc;
    project_point(m.ref_x, m.ref_y, rx, ry);
    mx = m.matched_x;
    my = m.matched_y;
    dx = (mx - rx * 16) / 16;
    dy = (my - ry * 16) / 16;
    v.is_correct = (dx * dx + dy * dy) < NEAR_SQ;
    v.score_now = '0;
    if (m.ref_index < KEYPOINTS) begin
      sc = hit_count[m.ref_index];
      if (v.is_correct && sc != SCORE_MAX) sc = sc + 1'b1;
      hit_count[m.ref_index] = sc;
      v.score_now = sc;
    end
    return v;
  endfunction

  function automatic void apply_reg(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
    case (addr)
      CFG_SCALE:  scale_q = data;
      CFG_COS:    cos_q = data;
      CFG_SIN:    sin_q = data;
      CFG_CENTER: centre_q = data[12:0];
      CFG_WIDTH:  width_q = data[12:0];
      CFG_HEIGHT: height_q = data[12:0];
      default: ;
    endcase
  endfunction

  // Mostly a point near the projection, so hits and near misses both occur
  function automatic match_t draw_match();
    match_t      m;
    longint      rx, ry, near_x, near_y;
    int unsigned lim_x, lim_y;
    lim_x = width_q;
    lim_y = height_q;
    lim_x = (lim_x * 16 > 65535) ? 65535 : lim_x * 16;
    lim_y = (lim_y * 16 > 65535) ? 65535 : lim_y * 16;
    m.ref_index = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 15)) : 10'($urandom());
    if ($urandom_range(0, 1) != 0) begin
      m.ref_x = 16'($urandom_range(0, lim_x));
      m.ref_y = 16'($urandom_range(0, lim_y));
    end else begin
      m.ref_x = 16'($urandom());
      m.ref_y = 16'($urandom());
    end
    project_point(m.ref_x, m.ref_y, rx, ry);
    near_x = rx * 16 + longint'($urandom_range(0, 80)) - 40;
    near_y = ry * 16 + longint'($urandom_range(0, 80)) - 40;
    if ($urandom_range(0, 3) != 0 && near_x >= 0 && near_x <= 131071)
      m.matched_x = 17'(near_x);
    else
      m.matched_x = 17'($urandom());
    if ($urandom_range(0, 3) != 0 && near_y >= 0 && near_y <= 131071)
      m.matched_y = 17'(near_y);
    else
      m.matched_y = 17'($urandom());
    return m;
  endfunction

  // A plausible rotation about a random centre
  function automatic reg_set_t draw_reg_set();
    reg_set_t s;
    int       c, sn;
    c  = int'($urandom_range(0, 32768)) - 16384;
    sn = int'($sqrt(real'(268435456 - c * c)));
    if ($urandom_range(0, 1) != 0) sn = -sn;
    s.scale  = 16'($urandom_range(1024, 16384));
    s.cosv   = 16'(c);
    s.sinv   = 16'(sn);
    s.centre = {3'($urandom()), 13'($urandom_range(1024, 7168))};
    s.width  = {3'($urandom()), 13'($urandom_range(1, 4096))};
    s.height = {3'($urandom()), 13'($urandom_range(1, 4096))};
    return s;
  endfunction

  function automatic void note_fault(input string what, input verdict_t want,
                                     input verdict_t got);
    fault_count++;
    if (fault_count <= SHOWN_MAX)
      $display("%0t %s: expected correct=%0b score=%0d, got correct=%0b score=%0d",
               $time, what, want.is_correct, want.score_now, got.is_correct,
               got.score_now);
  endfunction

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_addr = addr;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(addr, data);
  endtask

  // Load a full register set; the spare indexes must leave everything as it is
  task automatic load_reg_set(input reg_set_t s, input bit with_spares);
    cfg_write(CFG_SCALE, s.scale);
    if (with_spares) cfg_write(CFG_SPARE_LO, 16'($urandom()));
    cfg_write(CFG_COS, s.cosv);
    cfg_write(CFG_SIN, s.sinv);
    cfg_write(CFG_CENTER, s.centre);
    if (with_spares) cfg_write(CFG_SPARE_HI, 16'($urandom()));
    cfg_write(CFG_WIDTH, s.width);
    cfg_write(CFG_HEIGHT, s.height);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one match, with an optional idle gap first, and queue its verdict
  task automatic send_match(input match_t m, input bit typed, input verdict_t typed_v);
    int unsigned gap;
    verdict_t    v;
    gap = 0;
    if (!calm && gappy && $urandom_range(0, 2) == 0)
      gap = $urandom_range(1, 15);
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata = {4'd0, m.matched_y, m.matched_x, m.ref_y, m.ref_x, m.ref_index};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    v = judge_match(m);
    if (typed) v = typed_v;
    verdicts_due.push_back(v);
  endtask

  task automatic send_random_batch();
    for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
      if (k % 16 == 0) gappy = 1'($urandom_range(0, 1));
      send_match(draw_match(), 1'b0, '0);
    end
  endtask

  // Random result stalls in bursts, each followed by a ready burst; always ready once calm
  initial begin : result_backpressure
    int unsigned burst;
    forever begin
      burst = $urandom_range(1, 15);
      out_tready = (calm || out_tready !== 1'b1 || $urandom_range(0, 2) != 0) ? 1'b1 : 1'b0;
      repeat (burst) @(negedge clk);
    end
  end

  // Compare every result transfer with the oldest pending verdict
  always @(posedge clk) begin : check_results
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.is_correct = out_tdata[0];
      got.score_now = out_tdata[16:1];
      if (verdicts_due.size() == 0) begin
        note_fault("result with nothing pending", '0, got);
      end else begin
        want = verdicts_due.pop_front();
        if (got.is_correct !== want.is_correct || got.score_now !== want.score_now)
          note_fault("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    for (int i = 0; i < KEYPOINTS; i++) hit_count[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hand-worked rows, then random matches under the reset registers
    for (int r = 0; r < $size(probes); r++)
      send_match(probes[r].m, probes[r].typed, probes[r].v);
    send_random_batch();

    // Each later phase loads new registers once the block has gone quiet
    for (int p = 1; p < PHASES; p++) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      while (verdicts_due.size() != 0) @(posedge clk);
      if (p <= $size(fixed_sets))
        load_reg_set(fixed_sets[p - 1], p == $size(fixed_sets));
      else
        load_reg_set(draw_reg_set(), 1'b0);
      calm = (p == PHASES - 1);
      send_random_batch();
    end

    // Drain, then let the pipeline settle before the verdict
    @(negedge clk);
    in_tvalid = 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && verdicts_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mic_pkg.sv
sv/mic_mac.sv
sv/mic_score_ram.sv
sv/match_inlier_counter.sv
tb/tb_top.sv
